// ===== rtl/rtd_sample_validate_filter_trend_unit_assert.svh =====
// Assertion macros shared by the RTD filter block.
// Each takes a label, clock, active-low reset, antecedent and consequent.
`ifndef RTD_SAMPLE_VALIDATE_FILTER_TREND_UNIT_ASSERT_SVH
`define RTD_SAMPLE_VALIDATE_FILTER_TREND_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTDSVF_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
		else $error("rtdsvf assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RTDSVF_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
		else $error("rtdsvf assertion failed");

`endif

// ===== rtl/rtdsvf_pkg.sv =====
`default_nettype none

package rtdsvf_pkg;

	localparam int CODE_W     = 12;
	localparam int TIME_W     = 32;
	localparam int TEMP_W     = 24;
	localparam int SLOPE_W    = 20;
	localparam int ALPHA_W    = 17;
	localparam int PERIOD_W   = 16;
	localparam int PROD_W     = CODE_W + SLOPE_W;
	localparam int FRAC_SHIFT = 8;
	localparam int EMA_SHIFT  = 16;
	localparam int SAT_W      = 48;
	localparam int SCALE_W    = 10;
	// signed width of (ema - base) * 1000
	localparam int NUM_W      = TEMP_W + 1 + SCALE_W;
	localparam int EPROD_W    = ALPHA_W + 1 + TEMP_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [1:0]                status_t;
	typedef logic signed [TEMP_W-1:0]  temp_t;

	localparam status_t ST_VALID = 2'd0;
	localparam status_t ST_OPEN  = 2'd1;
	localparam status_t ST_SHORT = 2'd2;
	localparam status_t ST_RANGE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_RAW_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BENCH   = 3'd5;

	localparam logic [CODE_W-1:0]   OPEN_CODE_DEF       = 12'd4090;
	localparam logic [CODE_W-1:0]   SHORT_CODE_DEF      = 12'd5;
	localparam logic [PERIOD_W-1:0] TREND_PERIOD_MS_DEF = 16'd1000;

	localparam temp_t              BENCH_TEMP  = 24'sd6400;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
	localparam logic [SCALE_W-1:0] TREND_SCALE = 10'd1000;

	typedef struct packed {
		logic [CODE_W-1:0] adc_sample;
		logic [TIME_W-1:0] now_ms;
	} sample_t;

	typedef struct packed {
		status_t sensor_status;
		temp_t   raw_temp;
		temp_t   filtered_temp;
		temp_t   temp_rate;
		logic    rate_updated;
		logic    fault_open;
		logic    fault_short;
		logic    safe_stop;
	} result_t;

	typedef struct packed {
		logic [CODE_W-1:0]  raw_valid_min;
		logic [CODE_W-1:0]  raw_valid_max;
		logic [SLOPE_W-1:0] cal_slope;
		temp_t              cal_offset;
		logic [ALPHA_W-1:0] filter_alpha;
		logic               bench_mode;
	} cfg_t;

	// classified sample handed from front to back
	typedef struct packed {
		status_t           status;
		logic [CODE_W-1:0] code;
		logic [TIME_W-1:0] now_ms;
	} fe_item_t;

	// clamp a wide signed value to the Q8 temperature range
	function automatic temp_t sat_temp(input logic signed [SAT_W-1:0] x);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = {{(SAT_W-TEMP_W+1){1'b0}}, {(TEMP_W-1){1'b1}}};
		lo = {{(SAT_W-TEMP_W+1){1'b1}}, {(TEMP_W-1){1'b0}}};
		if (x > hi) begin
			sat_temp = {1'b0, {(TEMP_W-1){1'b1}}};
		end else if (x < lo) begin
			sat_temp = {1'b1, {(TEMP_W-1){1'b0}}};
		end else begin
			sat_temp = x[TEMP_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rtdsvf_front.sv =====
`default_nettype none

module rtdsvf_front #(
	parameter logic [rtdsvf_pkg::CODE_W-1:0] OPEN_CODE  = rtdsvf_pkg::OPEN_CODE_DEF,
	parameter logic [rtdsvf_pkg::CODE_W-1:0] SHORT_CODE = rtdsvf_pkg::SHORT_CODE_DEF
) (
	input  wire rtdsvf_pkg::sample_t  sample,
	input  wire                       sample_valid,
	output logic                      sample_stall,
	input  wire rtdsvf_pkg::cfg_t     cfg,
	input  wire                       q_full,
	output logic                      q_push,
	output rtdsvf_pkg::fe_item_t      q_item
);
	import rtdsvf_pkg::*;

	status_t status;

	// classify: open first, then short, then the configured window
	always_comb begin
		if (sample.adc_sample >= OPEN_CODE) begin
			status = ST_OPEN;
		end else if (sample.adc_sample <= SHORT_CODE) begin
			status = ST_SHORT;
		end else if (sample.adc_sample < cfg.raw_valid_min ||
				sample.adc_sample > cfg.raw_valid_max) begin
			status = ST_RANGE;
		end else begin
			status = ST_VALID;
		end
	end

	// transfer into the queue whenever it has room
	assign sample_stall   = q_full;
	assign q_push         = sample_valid && !q_full;
	assign q_item.status  = status;
	assign q_item.code    = sample.adc_sample;
	assign q_item.now_ms  = sample.now_ms;

endmodule

`default_nettype wire

// ===== rtl/rtdsvf_queue.sv =====
`default_nettype none
`include "rtd_sample_validate_filter_trend_unit_assert.svh"

module rtdsvf_queue (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       push,
	input  wire rtdsvf_pkg::fe_item_t push_item,
	output logic                      full,
	output logic                      head_valid,
	output rtdsvf_pkg::fe_item_t      head_item,
	input  wire                       pop
);
	import rtdsvf_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	fe_item_t          entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// store entry payload
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	`RTDSVF_ASSERT_IMP(a_q_no_overflow, clk, arst_n, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH))
	`RTDSVF_ASSERT_IMP(a_q_no_underflow, clk, arst_n, pop, count_q != '0)

endmodule

`default_nettype wire

// ===== rtl/rtdsvf_back.sv =====
`default_nettype none
`include "rtd_sample_validate_filter_trend_unit_assert.svh"

module rtdsvf_back #(
	parameter logic [rtdsvf_pkg::PERIOD_W-1:0] TREND_PERIOD_MS =
		rtdsvf_pkg::TREND_PERIOD_MS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire rtdsvf_pkg::cfg_t     cfg,
	input  wire                       q_valid,
	input  wire rtdsvf_pkg::fe_item_t q_item,
	output logic                      q_pop,
	output rtdsvf_pkg::result_t       result,
	output logic                      result_valid,
	input  wire                       result_stall
);
	import rtdsvf_pkg::*;

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] S_IDLE    = 3'd0;
	localparam logic [ST_W-1:0] S_CONV    = 3'd1;
	localparam logic [ST_W-1:0] S_EMA_MUL = 3'd2;
	localparam logic [ST_W-1:0] S_EMA     = 3'd3;
	localparam logic [ST_W-1:0] S_TREND   = 3'd4;
	localparam logic [ST_W-1:0] S_DIV     = 3'd5;
	localparam logic [ST_W-1:0] S_FIN     = 3'd6;
	localparam logic [ST_W-1:0] S_DONE    = 3'd7;

	localparam int DCNT_W = $clog2(NUM_W);
	localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(NUM_W - 1);

	logic [ST_W-1:0]     state_q;
	fe_item_t            item_q;
	logic [PROD_W-1:0]   prod_q;
	temp_t               raw_q;
	logic signed [EPROD_W-1:0] eprod_q;
	temp_t               ema_q;
	temp_t               base_temp_q;
	temp_t               rate_q;
	logic                primed_q;
	logic [TIME_W-1:0]   base_time_q;
	logic [1:0]          fault_q;
	logic                upd_q;
	logic                stop_q;
	logic [TIME_W-1:0]   dt_q;
	logic [NUM_W-1:0]    quo_q;
	logic [TIME_W-1:0]   rem_q;
	logic                neg_q;
	logic [DCNT_W-1:0]   dcnt_q;
	result_t             out_q;
	logic                out_valid_q;

	logic [ALPHA_W-1:0]        alpha_eff;
	logic signed [SAT_W-1:0]   conv_sum;
	logic signed [TEMP_W:0]    ema_diff;
	logic signed [EPROD_W-1:0] eprod;
	logic signed [EPROD_W-EMA_SHIFT-1:0] ema_step;
	logic signed [SAT_W-1:0]   ema_sum;
	logic [TIME_W-1:0]         dt;
	logic                      trend_due;
	logic signed [TEMP_W:0]    trend_diff;
	logic signed [NUM_W:0]     trend_num;
	logic [NUM_W:0]            num_mag;
	logic [TIME_W:0]           rem_sh;
	logic                      rem_ge;
	logic [TIME_W:0]           rem_sub;
	logic signed [SAT_W-1:0]   quo_ext;
	logic signed [SAT_W-1:0]   quo_sig;
	logic                      is_valid;
	logic                      is_fault;
	logic                      out_free;

	// conversion, EMA and trend datapath
	always_comb begin
		alpha_eff = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
		conv_sum  = $signed({{(SAT_W-PROD_W+FRAC_SHIFT){1'b0}}, prod_q[PROD_W-1:FRAC_SHIFT]})
			+ $signed({{(SAT_W-TEMP_W){cfg.cal_offset[TEMP_W-1]}}, cfg.cal_offset});
		ema_diff  = $signed({raw_q[TEMP_W-1], raw_q}) - $signed({ema_q[TEMP_W-1], ema_q});
		eprod     = $signed({1'b0, alpha_eff}) * ema_diff;
		// upper bits of the product are the shift rounded toward minus infinity
		ema_step  = $signed(eprod_q[EPROD_W-1:EMA_SHIFT]);
		ema_sum   = $signed({{(SAT_W-TEMP_W){ema_q[TEMP_W-1]}}, ema_q})
			+ $signed({{(SAT_W-EPROD_W+EMA_SHIFT){ema_step[EPROD_W-EMA_SHIFT-1]}}, ema_step});
		dt        = item_q.now_ms - base_time_q;
		trend_due = (dt >= {{(TIME_W-PERIOD_W){1'b0}}, TREND_PERIOD_MS}) && (dt != '0);
		trend_diff = $signed({ema_q[TEMP_W-1], ema_q})
			- $signed({base_temp_q[TEMP_W-1], base_temp_q});
		trend_num = trend_diff * $signed({1'b0, TREND_SCALE});
		num_mag   = trend_num[NUM_W] ? (NUM_W+1)'(-trend_num) : trend_num;
		rem_sh    = {rem_q, quo_q[NUM_W-1]};
		rem_ge    = rem_sh >= {1'b0, dt_q};
		rem_sub   = rem_sh - {1'b0, dt_q};
		quo_ext   = $signed({{(SAT_W-NUM_W){1'b0}}, quo_q});
		quo_sig   = neg_q ? -quo_ext : quo_ext;
		is_valid  = (item_q.status == ST_VALID);
		is_fault  = !is_valid && !cfg.bench_mode;
		out_free  = !out_valid_q || !result_stall;
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;

	// sequence one item through the shared datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ema_q       <= '0;
			base_temp_q <= '0;
			rate_q      <= '0;
			primed_q    <= 1'b0;
			base_time_q <= '0;
			fault_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// raise the result when it is loaded, drop it once taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_valid && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					state_q <= S_EMA_MUL;
				end
				S_EMA_MUL: begin
					state_q <= S_EMA;
				end
				S_EMA: begin
					if (is_fault) begin
						ema_q    <= '0;
						primed_q <= 1'b0;
						fault_q  <= fault_q | ((item_q.status == ST_SHORT) ? 2'b10 : 2'b01);
						state_q  <= S_DONE;
					end else begin
						fault_q <= '0;
						if (!primed_q) begin
							ema_q       <= raw_q;
							base_temp_q <= raw_q;
							primed_q    <= 1'b1;
							if (is_valid) begin
								base_time_q <= item_q.now_ms;
							end
						end else begin
							ema_q <= sat_temp(ema_sum);
						end
						state_q <= is_valid ? S_TREND : S_DONE;
					end
				end
				S_TREND: begin
					state_q <= trend_due ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (dcnt_q == DCNT_LAST) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					rate_q      <= sat_temp(quo_sig);
					base_temp_q <= ema_q;
					base_time_q <= item_q.now_ms;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				item_q <= q_item;
				prod_q <= q_item.code * cfg.cal_slope;
				upd_q  <= 1'b0;
				stop_q <= 1'b0;
			end
			S_CONV: begin
				if (is_valid) begin
					raw_q <= sat_temp(conv_sum);
				end else if (cfg.bench_mode) begin
					raw_q <= BENCH_TEMP;
				end else begin
					raw_q <= '0;
				end
			end
			S_EMA_MUL: begin
				eprod_q <= eprod;
			end
			S_EMA: begin
				stop_q <= is_fault;
			end
			S_TREND: begin
				dt_q   <= dt;
				neg_q  <= trend_num[NUM_W];
				quo_q  <= num_mag[NUM_W-1:0];
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			S_DIV: begin
				rem_q  <= rem_ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
				quo_q  <= {quo_q[NUM_W-2:0], rem_ge};
				dcnt_q <= dcnt_q + 1'b1;
			end
			S_FIN: begin
				upd_q <= 1'b1;
			end
			S_DONE: begin
				if (out_free) begin
					out_q.sensor_status <= item_q.status;
					out_q.raw_temp      <= raw_q;
					out_q.filtered_temp <= ema_q;
					out_q.temp_rate     <= rate_q;
					out_q.rate_updated  <= upd_q;
					out_q.fault_open    <= fault_q[0];
					out_q.fault_short   <= fault_q[1];
					out_q.safe_stop     <= stop_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

	`RTDSVF_ASSERT_IMP(a_stop_clears_filter, clk, arst_n, result_valid && result.safe_stop, result.filtered_temp == '0 && (result.fault_open || result.fault_short))
	`RTDSVF_ASSERT_IMP(a_trend_on_valid_only, clk, arst_n, result_valid && result.rate_updated, result.sensor_status == ST_VALID)
	`RTDSVF_ASSERT_NXT(a_div_exits_to_fin, clk, arst_n, state_q == S_DIV, state_q == S_DIV || state_q == S_FIN)

endmodule

`default_nettype wire

// ===== rtl/rtd_sample_validate_filter_trend_unit.sv =====
`default_nettype none

// RTD sample validation, EMA filter and trend unit. Each transfer on the
// sample channel carries one 12-bit converter code and a millisecond
// timestamp; each produces exactly one result: status, converted temperature,
// filtered temperature, last trend in C/s (all signed Q8) and sticky fault
// flags. The front classifies samples into a two-entry queue; the back
// works one item at a time through a shared datapath; faulted or substituted
// samples end after the EMA step, valid ones go on to the trend check, and
// a trend update runs the 35-step serial divider for (ema - base) * 1000 / dt.
// Configuration writes take effect at once and belong in idle periods.
module rtd_sample_validate_filter_trend_unit #(
	parameter logic [rtdsvf_pkg::CODE_W-1:0]   OPEN_CODE       = rtdsvf_pkg::OPEN_CODE_DEF,
	parameter logic [rtdsvf_pkg::CODE_W-1:0]   SHORT_CODE      = rtdsvf_pkg::SHORT_CODE_DEF,
	parameter logic [rtdsvf_pkg::PERIOD_W-1:0] TREND_PERIOD_MS =
		rtdsvf_pkg::TREND_PERIOD_MS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire rtdsvf_pkg::sample_t              sample,
	input  wire                                   sample_valid,
	output logic                                  sample_stall,
	output rtdsvf_pkg::result_t                   result,
	output logic                                  result_valid,
	input  wire                                   result_stall,
	input  wire                                   cfg_we,
	input  wire [rtdsvf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [rtdsvf_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import rtdsvf_pkg::*;

	cfg_t     cfg_q;
	logic     q_full;
	logic     q_push;
	fe_item_t q_in;
	logic     q_valid;
	fe_item_t q_head;
	logic     q_pop;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.raw_valid_min <= '0;
			cfg_q.raw_valid_max <= '1;
			cfg_q.cal_slope     <= SLOPE_W'(6554);
			cfg_q.cal_offset    <= '0;
			cfg_q.filter_alpha  <= ALPHA_W'(6554);
			cfg_q.bench_mode    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RAW_MIN: cfg_q.raw_valid_min <= cfg_data[CODE_W-1:0];
				REG_RAW_MAX: cfg_q.raw_valid_max <= cfg_data[CODE_W-1:0];
				REG_SLOPE:   cfg_q.cal_slope     <= cfg_data[SLOPE_W-1:0];
				REG_OFFSET:  cfg_q.cal_offset    <= $signed(cfg_data[TEMP_W-1:0]);
				REG_ALPHA:   cfg_q.filter_alpha  <= cfg_data[ALPHA_W-1:0];
				REG_BENCH:   cfg_q.bench_mode    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	rtdsvf_front #(
		.OPEN_CODE  (OPEN_CODE),
		.SHORT_CODE (SHORT_CODE)
	) u_front (
		.sample       (sample),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.cfg          (cfg_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_in)
	);

	rtdsvf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_in),
		.full       (q_full),
		.head_valid (q_valid),
		.head_item  (q_head),
		.pop        (q_pop)
	);

	rtdsvf_back #(
		.TREND_PERIOD_MS (TREND_PERIOD_MS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_item       (q_head),
		.q_pop        (q_pop),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

`default_nettype wire
